>>> src/srmg_pkg.sv
// Package for the set range and minimum gap block.
// Holds the payload structs, status codes and the controller/datapath link types.
// No dependencies.
package srmg_pkg;

  localparam int unsigned CountW = 7;
  localparam int unsigned ValueW = 32;

  localparam logic [CountW-1:0] CAP_RESET = 7'd64;
  localparam logic [ValueW-1:0] SIGN_BIAS = 32'h8000_0000;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_REJECTED = 2'd1;
  localparam logic [1:0] STATUS_EMPTY    = 2'd2;
  localparam logic [1:0] STATUS_SINGLE   = 2'd3;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic [CountW-1:0]        repeat_count;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [CountW-1:0] element_count;
    logic [ValueW-1:0] longest_span;
    logic [ValueW-1:0] shortest_span;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // latch the accepted input beat
    logic scan;    // issue one store read and step the address
    logic commit;  // update the set state and load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_scan;  // the input beat inserts into a non-empty store
    logic scan_last;  // the current read address is the last held entry
    logic busy;       // reads still in flight through the gap pipeline
  } sts_t;

endpackage

>>> src/srmg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srmg_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/srmg_ctrl.sv
// Controller state machine for the set range and minimum gap block.
// Depends on srmg_pkg for the command and status structs.
module srmg_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  srmg_pkg::sts_t sts_i,
  output srmg_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   slot_free;

  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.need_scan ? S_SCAN : S_COMMIT;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts_i.busy) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> src/srmg_dp.sv
// Datapath for the set range and minimum gap block: value store, nearest
// distance scan, running minimum, maximum and gap, and the result register.
// Depends on srmg_pkg and srmg_ram.
module srmg_dp #(
  parameter int unsigned StoreDepth = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  srmg_pkg::in_t                    in_data_i,
  input  logic                             cfg_we_i,
  input  logic [srmg_pkg::CountW-1:0]      cfg_data_i,
  input  srmg_pkg::cmd_t                   cmd_i,
  output srmg_pkg::sts_t                   sts_o,
  output srmg_pkg::out_t                   out_data_o
);

  localparam int unsigned AddrW = $clog2(StoreDepth);
  localparam int unsigned CW    = srmg_pkg::CountW;
  localparam int unsigned VW    = srmg_pkg::ValueW;
  localparam logic [CW-1:0] DepthC = CW'(StoreDepth);

  // Configuration and set state.
  logic [CW-1:0]  cap_q;
  logic [CW-1:0]  count_q, count_d;
  logic [CW-1:0]  entries_q;
  logic [VW-1:0]  min_q, min_d;
  logic [VW-1:0]  max_q, max_d;
  logic [VW:0]    gap_q, gap_d;

  // Per-item registers.
  logic [VW-1:0]  key_q;
  logic [CW-1:0]  copies_q;
  logic           reject_q;
  logic [AddrW-1:0] rd_addr_q;
  logic           rd_vld_q;
  logic           diff_vld_q;
  logic [VW-1:0]  diff_q;
  logic [VW:0]    near_q;
  srmg_pkg::out_t out_q, out_d;

  logic [CW-1:0]  limit;
  logic [CW:0]    want_now;
  logic           reject_now;
  logic [VW-1:0]  rd_data;
  logic [VW:0]    sub_up;
  logic [VW-1:0]  abs_diff;
  logic           ins;
  logic           ins_write;

  assign limit      = (cap_q > DepthC) ? DepthC : cap_q;
  assign want_now   = {1'b0, count_q} + {1'b0, in_data_i.repeat_count};
  assign reject_now = want_now > {1'b0, limit};

  assign sts_o.need_scan = !reject_now && (in_data_i.repeat_count != '0) &&
                           (entries_q != '0);
  assign sts_o.scan_last = (CW'(rd_addr_q) + CW'(1)) == entries_q;
  assign sts_o.busy      = rd_vld_q || diff_vld_q;

  assign ins       = !reject_q && (copies_q != '0);
  assign ins_write = cmd_i.commit && ins;

  // One store entry per accepted insert; copies live only in the count.
  srmg_ram #(
    .Width (VW),
    .Depth (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ins_write),
    .waddr_i (entries_q[AddrW-1:0]),
    .wdata_i (key_q),
    .re_i    (cmd_i.scan),
    .raddr_i (rd_addr_q),
    .rdata_o (rd_data)
  );

  // The nearest held value to the new key is its sorted neighbor, so the
  // smallest absolute difference equals the smaller of the two neighbor gaps.
  assign sub_up   = {1'b0, key_q} - {1'b0, rd_data};
  assign abs_diff = sub_up[VW] ? (rd_data - key_q) : sub_up[VW-1:0];

  always_comb begin
    count_d = count_q;
    min_d   = min_q;
    max_d   = max_q;
    gap_d   = gap_q;
    if (ins) begin
      count_d = count_q + copies_q;
      if (count_q == '0 || key_q < min_q) begin
        min_d = key_q;
      end
      if (count_q == '0 || key_q > max_q) begin
        max_d = key_q;
      end
      if (copies_q >= CW'(2)) begin
        gap_d = '0;
      end else if (near_q < gap_q) begin
        gap_d = near_q;
      end
    end

    out_d               = '0;
    out_d.element_count = count_d;
    if (reject_q) begin
      out_d.status = srmg_pkg::STATUS_REJECTED;
    end else if (count_d == '0) begin
      out_d.status = srmg_pkg::STATUS_EMPTY;
    end else if (count_d == CW'(1)) begin
      out_d.status = srmg_pkg::STATUS_SINGLE;
    end else begin
      out_d.status        = srmg_pkg::STATUS_OK;
      out_d.longest_span  = max_d - min_d;
      out_d.shortest_span = gap_d[VW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q      <= srmg_pkg::CAP_RESET;
      count_q    <= '0;
      entries_q  <= '0;
      gap_q      <= '1;
      rd_vld_q   <= 1'b0;
      diff_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      rd_vld_q   <= cmd_i.scan;
      diff_vld_q <= rd_vld_q;
      if (cmd_i.commit) begin
        count_q <= count_d;
        gap_q   <= gap_d;
        if (ins) begin
          entries_q <= entries_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q     <= in_data_i.value ^ srmg_pkg::SIGN_BIAS;
      copies_q  <= in_data_i.repeat_count;
      reject_q  <= reject_now;
      rd_addr_q <= '0;
      near_q    <= '1;
    end else begin
      if (cmd_i.scan) begin
        rd_addr_q <= rd_addr_q + AddrW'(1);
      end
      if (diff_vld_q && ({1'b0, diff_q} < near_q)) begin
        near_q <= {1'b0, diff_q};
      end
    end
    if (rd_vld_q) begin
      diff_q <= abs_diff;
    end
    if (cmd_i.commit) begin
      min_q <= min_d;
      max_q <= max_d;
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

>>> src/set_range_and_min_gap.sv
// Set range and minimum gap: each input beat adds a signed value repeated
// repeat_count times to a bounded multiset and returns one result beat with
// status, element count, max-minus-min span and smallest neighbor gap. An
// item that needs no store read (rejected, zero repeat count, or empty set)
// goes straight from acceptance to the commit state. Otherwise the single
// read port of the value store is swept once over the held entries, one
// entry per cycle, to find the held value nearest the new one. The result
// waits in an output register, so a new beat is taken while the previous
// result is still unread. The capacity register is always ready; the
// effective limit is min(capacity, MAX_ELEMENTS).
// Depends on srmg_pkg, srmg_ctrl, srmg_dp and srmg_ram.
module set_range_and_min_gap #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  srmg_pkg::in_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output srmg_pkg::out_t              out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [srmg_pkg::CountW-1:0] cfg_data_i
);

  // The count field is 7 bits, so no more than 127 values can ever be held.
  localparam int unsigned StoreDepth = (MAX_ELEMENTS < 127) ? MAX_ELEMENTS : 127;

  srmg_pkg::cmd_t cmd;
  srmg_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  srmg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  srmg_dp #(
    .StoreDepth (StoreDepth)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

  // One item at a time: an accepted beat closes the input until it commits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while an item is in progress");

  // Spans are reported only for a set of two or more values.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != srmg_pkg::STATUS_OK) |->
      (out_data_o.longest_span == '0) && (out_data_o.shortest_span == '0))
    else $error("nonzero span with a non-ok status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == srmg_pkg::STATUS_OK) |->
      (out_data_o.element_count >= 7'd2))
    else $error("ok status with fewer than two values");

  // Every gap lies between two held values, so it cannot exceed the range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == srmg_pkg::STATUS_OK) |->
      (out_data_o.shortest_span <= out_data_o.longest_span))
    else $error("shortest span exceeds longest span");

endmodule
